/* sv/lsrd_pkg.sv */
// ----------------------------------------------------------------------------
// lsrd_pkg: shared types and constants of the LED shift-register driver.
// Command codes, transaction structs and the back-end sequencer states.
// ----------------------------------------------------------------------------
package lsrd_pkg;

	localparam int LED_COUNT_DEFAULT   = 8;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	typedef enum logic [1:0] {
		CMD_SET     = 2'd0,
		CMD_READ    = 2'd1,
		CMD_TOGGLE  = 2'd2,
		CMD_REFRESH = 2'd3
	} cmd_t;

	localparam logic KIND_PIN  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		cmd_t       command;
		logic [3:0] led_index;
		logic       led_on;
	} cmd_item_t;

	typedef struct packed {
		logic kind;
		logic serial_level;
		logic shift_clock_level;
		logic latch_level;
		logic lit_answer;
		logic last;
	} res_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_BIT_LO,
		BK_BIT_SER,
		BK_BIT_HI,
		BK_CLK_LO,
		BK_LATCH_HI,
		BK_LATCH_LO
	} bk_state_t;

endpackage

/* sv/lsrd_queue.sv */
// ----------------------------------------------------------------------------
// lsrd_queue: short job queue between the front end and the back end.
// A small circular buffer with push, pop and full/empty flags.
// ----------------------------------------------------------------------------
module lsrd_queue #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign avail    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/lsrd_front.sv */
// ----------------------------------------------------------------------------
// lsrd_front: command front end.
// Holds the wanted and shown patterns, applies set and toggle at once and
// queues read answers and refresh jobs for the back end.
// ----------------------------------------------------------------------------
module lsrd_front #(
	parameter int LED_COUNT = lsrd_pkg::LED_COUNT_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  lsrd_pkg::cmd_item_t    cmd_data,
	output logic                   job_push,
	output logic [LED_COUNT+1:0]   job_data,
	input  logic                   job_full
);
	import lsrd_pkg::*;

	logic [LED_COUNT-1:0] wanted_q;
	logic [LED_COUNT-1:0] shown_q;
	logic [LED_COUNT-1:0] mask;
	logic                 idx_ok;
	logic                 accept;
	logic                 lit;

	assign cmd_stall = job_full;
	assign accept    = cmd_valid && !job_full;
	assign idx_ok    = ({2'b00, cmd_data.led_index} < 6'(LED_COUNT));
	assign mask      = idx_ok ? (LED_COUNT'(1) << cmd_data.led_index) : '0;
	// Patterns are active low: a clear bit means the LED is lit.
	assign lit       = idx_ok && ((wanted_q & mask) == '0);

	always_comb begin
		job_push = 1'b0;
		job_data = {1'b0, 1'b0, wanted_q};
		if (accept) begin
			unique case (cmd_data.command)
				CMD_READ: begin
					job_push = 1'b1;
					job_data = {1'b1, lit, wanted_q};
				end
				CMD_REFRESH: begin
					job_push = (wanted_q != shown_q);
				end
				default: begin
					job_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= '1;
			shown_q  <= '0;
		end else if (accept) begin
			unique case (cmd_data.command)
				CMD_SET: begin
					wanted_q <= cmd_data.led_on ? (wanted_q & ~mask) : (wanted_q | mask);
				end
				CMD_TOGGLE: begin
					wanted_q <= wanted_q ^ mask;
				end
				CMD_REFRESH: begin
					shown_q <= wanted_q;
				end
				default: begin
					wanted_q <= wanted_q;
				end
			endcase
		end
	end

endmodule

/* sv/lsrd_back.sv */
// ----------------------------------------------------------------------------
// lsrd_back: result back end.
// Pops jobs from the queue and plays out read answers and the pin steps of
// a serial shift-register load into a registered result stage.
// ----------------------------------------------------------------------------
module lsrd_back #(
	parameter int LED_COUNT = lsrd_pkg::LED_COUNT_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_avail,
	input  logic [LED_COUNT+1:0]   job_data,
	output logic                   job_pop,
	output logic                   res_valid,
	input  logic                   res_stall,
	output lsrd_pkg::res_item_t    res_data
);
	import lsrd_pkg::*;

	localparam int CNT_W = $clog2(LED_COUNT + 1);

	bk_state_t            state_q;
	bk_state_t            state_d;
	logic [LED_COUNT-1:0] pattern_q;
	logic [LED_COUNT-1:0] pattern_d;
	logic [CNT_W-1:0]     bits_q;
	logic [CNT_W-1:0]     bits_d;
	logic                 serial_q;
	logic                 serial_d;
	logic                 out_valid_q;
	res_item_t            out_q;
	res_item_t            out_d;
	logic                 emit;
	logic                 slot_free;

	assign slot_free = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	always_comb begin
		state_d   = state_q;
		pattern_d = pattern_q;
		bits_d    = bits_q;
		serial_d  = serial_q;
		job_pop   = 1'b0;
		emit      = 1'b0;
		out_d     = '{kind: KIND_PIN, serial_level: serial_q, shift_clock_level: 1'b0,
			latch_level: 1'b0, lit_answer: 1'b0, last: 1'b0};
		if (slot_free) begin
			unique case (state_q)
				BK_IDLE: begin
					if (job_avail) begin
						job_pop = 1'b1;
						emit    = 1'b1;
						if (job_data[LED_COUNT+1]) begin
							out_d.kind         = KIND_READ;
							out_d.serial_level = 1'b0;
							out_d.lit_answer   = job_data[LED_COUNT];
							out_d.last         = 1'b1;
						end else begin
							pattern_d = job_data[LED_COUNT-1:0];
							bits_d    = CNT_W'(LED_COUNT);
							state_d   = BK_BIT_LO;
						end
					end
				end
				BK_BIT_LO: begin
					emit    = 1'b1;
					state_d = BK_BIT_SER;
				end
				BK_BIT_SER: begin
					emit               = 1'b1;
					serial_d           = pattern_q[LED_COUNT-1];
					out_d.serial_level = pattern_q[LED_COUNT-1];
					state_d            = BK_BIT_HI;
				end
				BK_BIT_HI: begin
					emit                    = 1'b1;
					out_d.shift_clock_level = 1'b1;
					pattern_d               = pattern_q << 1;
					bits_d                  = bits_q - 1'b1;
					state_d = (bits_q == CNT_W'(1)) ? BK_CLK_LO : BK_BIT_LO;
				end
				BK_CLK_LO: begin
					emit    = 1'b1;
					state_d = BK_LATCH_HI;
				end
				BK_LATCH_HI: begin
					emit              = 1'b1;
					out_d.latch_level = 1'b1;
					state_d           = BK_LATCH_LO;
				end
				BK_LATCH_LO: begin
					emit       = 1'b1;
					out_d.last = 1'b1;
					state_d    = BK_IDLE;
				end
				default: begin
					state_d = BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			bits_q      <= '0;
			serial_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			bits_q   <= bits_d;
			serial_q <= serial_d;
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		pattern_q <= pattern_d;
		if (slot_free && emit) begin
			out_q <= out_d;
		end
	end

endmodule

/* sv/led_shift_register_driver.sv */
// ----------------------------------------------------------------------------
// led_shift_register_driver: command-driven driver for a serial-in shift
// register (595 style) feeding active-low LEDs.
//
// The block keeps the wanted LED pattern and the pattern last loaded into the
// shift register. Set and toggle change the wanted pattern and produce no
// result; an index of LED_COUNT or more is ignored. A read returns one result
// transaction with kind set and lit_answer high when the LED is lit (an
// out-of-range index reads as dark). A refresh produces nothing when the
// patterns already match; otherwise it produces 3*LED_COUNT+4 pin-level
// transactions (28 for eight LEDs): one idle step, then for every bit, MSB
// first, clock low, serial data, clock high, and finally clock low, latch
// high and latch low, the last one flagged with last. The front end takes a
// command transaction every cycle as long as its four-entry job queue has
// room, so set and toggle wait behind a refresh in flight only when that
// queue is full. The back end emits one result per cycle, while res_stall is
// low, into a registered output stage; a refresh thus occupies the result
// channel for all its pin-level transactions and a read for its single one,
// and that output sequencer sets the sustained rate. Commands stall only
// when the queue is full. The serial pin level held between refreshes is
// zero after reset.
// ----------------------------------------------------------------------------
module led_shift_register_driver #(
	parameter int LED_COUNT   = lsrd_pkg::LED_COUNT_DEFAULT,
	parameter int QUEUE_DEPTH = lsrd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  lsrd_pkg::cmd_item_t cmd_data,
	output logic                res_valid,
	input  logic                res_stall,
	output lsrd_pkg::res_item_t res_data
);
	import lsrd_pkg::*;

	// Job word: read flag, read answer, pattern snapshot for a refresh.
	localparam int JOB_W = LED_COUNT + 2;

	logic             push;
	logic [JOB_W-1:0] push_data;
	logic             full;
	logic             pop;
	logic             avail;
	logic [JOB_W-1:0] pop_data;

	// The front end classifies each command transaction and updates the
	// wanted pattern right away, so later commands see its effect at once.
	lsrd_front #(
		.LED_COUNT(LED_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data),
		.job_push (push),
		.job_data (push_data),
		.job_full (full)
	);

	// Reads and refreshes wait here in order, decoupling the two sides.
	lsrd_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.avail    (avail),
		.pop_data (pop_data)
	);

	// The back end turns each job into result transactions, one per cycle while res_stall is low.
	lsrd_back #(
		.LED_COUNT(LED_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_avail(avail),
		.job_data (pop_data),
		.job_pop  (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

endmodule

/* test/tb_led_shift_register_driver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_shift_register_driver: self-checking bench for the LED driver.
// A short table of commands exercises reset state, range limits, read, set,
// toggle and refresh. Random commands follow, under random idling on both
// channels and one long result hold-off. Every result is compared against an
// in-bench model of the wanted and shown LED patterns or a row's typed answer.
// ----------------------------------------------------------------------------
module tb_led_shift_register_driver;
	import lsrd_pkg::*;

	localparam int LEDS         = LED_COUNT_DEFAULT;
	localparam int POS_W        = $clog2(LEDS);
	localparam int RANDOM_ITEMS = 110;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 400000;

	// One row of the directed table. Rows with a typed answer are reads whose
	// outcome is obvious from the pattern built up by the rows above them.
	typedef struct packed {
		cmd_t       op;
		logic [3:0] idx;
		logic       on;
		logic       typed;
		logic       lit;
	} dir_row_t;

	// The typed answer of a command, paired with it in acceptance order.
	typedef struct packed {
		logic      typed;
		res_item_t answer;
	} typed_answer_t;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd_data;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_data;

	// Bench copy of the block state.
	logic [LEDS-1:0] wanted_leds;
	logic [LEDS-1:0] shown_leds;
	logic            serial_hold;

	res_item_t     expected_results[$];
	typed_answer_t typed_answers[$];

	int  error_count;
	int  cycle_count;
	int  commands_taken;
	int  loads_seen;
	int  reads_seen;
	int  results_checked;
	bit  burst_mode;
	bit  hold_request;

	dir_row_t directed_rows [22] = '{
		'{CMD_READ,    4'd0,  1'b0, 1'b1, 1'b0},
		'{CMD_READ,    4'd15, 1'b0, 1'b1, 1'b0},
		'{CMD_REFRESH, 4'd0,  1'b0, 1'b0, 1'b0},
		'{CMD_REFRESH, 4'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_SET,     4'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_READ,    4'd0,  1'b0, 1'b1, 1'b1},
		'{CMD_SET,     4'd7,  1'b1, 1'b0, 1'b0},
		'{CMD_READ,    4'd7,  1'b0, 1'b1, 1'b1},
		'{CMD_SET,     4'd8,  1'b1, 1'b0, 1'b0},
		'{CMD_READ,    4'd8,  1'b0, 1'b1, 1'b0},
		'{CMD_SET,     4'd15, 1'b1, 1'b0, 1'b0},
		'{CMD_TOGGLE,  4'd3,  1'b0, 1'b0, 1'b0},
		'{CMD_READ,    4'd3,  1'b0, 1'b1, 1'b1},
		'{CMD_TOGGLE,  4'd3,  1'b1, 1'b0, 1'b0},
		'{CMD_READ,    4'd3,  1'b1, 1'b1, 1'b0},
		'{CMD_TOGGLE,  4'd12, 1'b0, 1'b0, 1'b0},
		'{CMD_REFRESH, 4'd0,  1'b0, 1'b0, 1'b0},
		'{CMD_SET,     4'd0,  1'b0, 1'b0, 1'b0},
		'{CMD_SET,     4'd7,  1'b0, 1'b0, 1'b0},
		'{CMD_SET,     4'd5,  1'b0, 1'b0, 1'b0},
		'{CMD_REFRESH, 4'd0,  1'b0, 1'b0, 1'b0},
		'{CMD_REFRESH, 4'd0,  1'b0, 1'b0, 1'b0}
	};

	led_shift_register_driver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length for one transaction. During a burst neither side idles.
	function automatic int draw_gap();
		return burst_mode ? 0 : int'($urandom_range(0, 10));
	endfunction

	function automatic res_item_t pin_step(logic ser, logic sck, logic lat);
		res_item_t step;
		step = '{KIND_PIN, ser, sck, lat, 1'b0, 1'b0};
		return step;
	endfunction

	// Applies one accepted command to the bench state and queues every result
	// it should produce, in order.
	task automatic predict_command(input cmd_item_t c);
		logic             in_range;
		logic [POS_W-1:0] pos;
		logic [LEDS-1:0]  load;
		res_item_t        answer;
		in_range = (c.led_index < LEDS);
		pos      = c.led_index[POS_W-1:0];
		case (c.command)
			CMD_SET: begin
				if (in_range)
					wanted_leds[pos] = ~c.led_on;
			end
			CMD_READ: begin
				// A cleared bit means the LED is lit.
				answer = '{KIND_READ, 1'b0, 1'b0, 1'b0,
					in_range && !wanted_leds[pos], 1'b1};
				expected_results.push_back(answer);
				reads_seen++;
			end
			CMD_TOGGLE: begin
				if (in_range)
					wanted_leds[pos] = ~wanted_leds[pos];
			end
			CMD_REFRESH: begin
				if (wanted_leds != shown_leds) begin
					load = wanted_leds;
					expected_results.push_back(pin_step(serial_hold, 1'b0, 1'b0));
					for (int b = LEDS - 1; b >= 0; b--) begin
						expected_results.push_back(pin_step(serial_hold, 1'b0, 1'b0));
						serial_hold = load[b];
						expected_results.push_back(pin_step(serial_hold, 1'b0, 1'b0));
						expected_results.push_back(pin_step(serial_hold, 1'b1, 1'b0));
					end
					expected_results.push_back(pin_step(serial_hold, 1'b0, 1'b0));
					expected_results.push_back(pin_step(serial_hold, 1'b0, 1'b1));
					answer = pin_step(serial_hold, 1'b0, 1'b0);
					answer.last = 1'b1;
					expected_results.push_back(answer);
					shown_leds = load;
					loads_seen++;
				end
			end
		endcase
	endtask

	function automatic void compare_field(string name, logic exp_bit, logic got_bit);
		if (exp_bit !== got_bit) begin
			$error("result field %s: expected %0d, got %0d", name, exp_bit, got_bit);
			error_count++;
		end
	endfunction

	// Command and result monitor. Both channels are sampled at the clock edge,
	// before the bench drives new values, so the acceptance seen here is the
	// one the block sees. Prediction comes first so that a result in the same
	// cycle as its command could still be matched.
	always @(posedge clk) begin
		typed_answer_t pin;
		res_item_t     exp_res;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				commands_taken++;
				pin = typed_answers.pop_front();
				predict_command(cmd_data);
				// A typed answer stands in for the read answer just predicted.
				if (pin.typed)
					expected_results[$] = pin.answer;
			end
			if (res_valid && !res_stall) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					$error("result transaction arrived with none expected");
					error_count++;
				end else begin
					exp_res = expected_results.pop_front();
					compare_field("kind",              exp_res.kind,
						res_data.kind);
					compare_field("serial_level",      exp_res.serial_level,
						res_data.serial_level);
					compare_field("shift_clock_level", exp_res.shift_clock_level,
						res_data.shift_clock_level);
					compare_field("latch_level",       exp_res.latch_level,
						res_data.latch_level);
					compare_field("lit_answer",        exp_res.lit_answer,
						res_data.lit_answer);
					compare_field("last",              exp_res.last,
						res_data.last);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("led_shift_register_driver verification failed");
			$finish;
		end
	end

	// Offers one command transaction after an idle gap and returns at the
	// edge where it is taken. With no gap, valid simply stays high.
	task automatic send_command(input cmd_item_t c, input logic typed, input logic lit,
		input int gap);
		typed_answer_t pin;
		pin.typed  = typed;
		pin.answer = '{KIND_READ, 1'b0, 1'b0, 1'b0, lit, 1'b1};
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_answers.push_back(pin);
		cmd_valid <= 1'b1;
		cmd_data  <= c;
		do
			@(posedge clk);
		while (!(cmd_valid && !cmd_stall));
	endtask

	// Result side: random stall before each transaction, plus one long
	// hold-off on request while commands keep coming.
	initial begin
		int hold;
		res_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold = HOLD_CYCLES;
			end else begin
				hold = draw_gap();
			end
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (!(res_valid && !res_stall));
		end
	end

	initial begin
		cmd_item_t c;
		int        pick;
		clk             = 1'b0;
		arst_n          = 1'b0;
		cmd_valid       = 1'b0;
		cmd_data        = '0;
		wanted_leds     = '1;
		shown_leds      = '0;
		serial_hold     = 1'b0;
		error_count     = 0;
		cycle_count     = 0;
		commands_taken  = 0;
		loads_seen      = 0;
		reads_seen      = 0;
		results_checked = 0;
		burst_mode      = 1'b0;
		hold_request    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (directed_rows[i]) begin
			c.command   = directed_rows[i].op;
			c.led_index = directed_rows[i].idx;
			c.led_on    = directed_rows[i].on;
			send_command(c, directed_rows[i].typed, directed_rows[i].lit, draw_gap());
		end

		// Random commands. Items 40 to 69 run back to back on both sides.
		// Items 80 to 99 alternate toggle and refresh with no gaps while the
		// result side holds off, so the job queue fills and stalls commands.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			burst_mode = (i >= 40 && i < 70);
			if (i == 80)
				hold_request = 1'b1;
			if (i >= 80 && i < 100) begin
				c.command   = (i % 2 == 0) ? CMD_TOGGLE : CMD_REFRESH;
				c.led_index = 4'($urandom_range(0, LEDS - 1));
				c.led_on    = 1'($urandom_range(0, 1));
				send_command(c, 1'b0, 1'b0, 0);
			end else begin
				pick = int'($urandom_range(0, 99));
				if (pick < 30)
					c.command = CMD_SET;
				else if (pick < 50)
					c.command = CMD_READ;
				else if (pick < 75)
					c.command = CMD_TOGGLE;
				else
					c.command = CMD_REFRESH;
				if ($urandom_range(0, 6) == 0)
					c.led_index = 4'($urandom_range(8, 15));
				else
					c.led_index = 4'($urandom_range(0, LEDS - 1));
				c.led_on = 1'($urandom_range(0, 1));
				send_command(c, 1'b0, 1'b0, draw_gap());
			end
		end
		burst_mode = 1'b0;
		cmd_valid <= 1'b0;

		// Drain, then give any stray result time to show up.
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			error_count++;
		end

		$display("Run covered %0d commands: %0d pattern loads and %0d reads,",
			commands_taken, loads_seen, reads_seen);
		$display("with %0d result transactions compared field by field.", results_checked);
		if (error_count == 0) begin
			$display("led_shift_register_driver verification clean");
		end else begin
			$display("led_shift_register_driver verification failed");
		end
		$finish;
	end

endmodule
